@@ rtl/core/dmm_pkg.sv @@
// shared types, constants and helpers for the degenerate motif window matcher
package dmm_pkg;

    localparam int unsigned BASES = 32;
    localparam int unsigned CNT_W = $clog2(BASES + 1);
    localparam int unsigned LEN_W = 6;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned IDX_W = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ALLOW_A = 3'd0;
    localparam logic [IDX_W-1:0] REG_ALLOW_C = 3'd1;
    localparam logic [IDX_W-1:0] REG_ALLOW_G = 3'd2;
    localparam logic [IDX_W-1:0] REG_ALLOW_T = 3'd3;
    localparam logic [IDX_W-1:0] REG_LENGTH  = 3'd4;
    localparam logic [IDX_W-1:0] REG_LIMIT   = 3'd5;
    localparam logic [IDX_W-1:0] REG_MODE    = 3'd6;
    localparam logic [IDX_W-1:0] REG_DEDUP   = 3'd7;

    // strand mode codes
    localparam logic [MODE_W-1:0] MODE_FWD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REV  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOTH = 2'd2;

    typedef logic [BASES-1:0] t_plane;

    typedef struct packed {
        logic            ok;
        logic            pal;
        logic            fwd_en;
        logic            rev_en;
        logic            dedup;
        logic [CNT_W-1:0] limit;
        t_plane          active;
        t_plane          fa;
        t_plane          fc;
        t_plane          fg;
        t_plane          ft;
        t_plane          ra;
        t_plane          rc;
        t_plane          rg;
        t_plane          rt;
    } t_motif;

    function automatic t_plane bit_rev(input t_plane v);
        t_plane r;
        for (int i = 0; i < BASES; i++) begin
            r[i] = v[BASES-1-i];
        end
        return r;
    endfunction

    // adder tree popcount of a 32-bit plane
    function automatic logic [CNT_W-1:0] popcount(input t_plane v);
        logic [1:0] s1 [16];
        logic [2:0] s2 [8];
        logic [3:0] s3 [4];
        logic [4:0] s4 [2];
        for (int i = 0; i < 16; i++) begin
            s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        end
        return {1'b0, s4[0]} + {1'b0, s4[1]};
    endfunction

    // positions that take part in one mismatch plane
    function automatic t_plane mismatch(input t_plane lo, input t_plane hi,
                                        input t_plane vld, input t_plane a,
                                        input t_plane c, input t_plane g,
                                        input t_plane t, input t_plane act);
        t_plane okb;
        okb = (~lo & ~hi & a) | (lo & ~hi & c) | (~lo & hi & g) | (lo & hi & t);
        return act & (~okb | ~vld);
    endfunction

endpackage

@@ rtl/core/dmm_cfg.sv @@
// configuration registers and registered motif derivation
module dmm_cfg
    import dmm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [BASES-1:0] i_cfg_data,
    output t_motif           o_motif
);

    t_plane            r_a, r_c, r_g, r_t;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_limit;
    logic [MODE_W-1:0] r_mode;
    logic              r_dedup;
    t_motif            r_motif;
    t_motif            n_motif;

    t_plane            active;
    t_plane            allow_any;
    logic [LEN_W-1:0]  rshift;
    t_plane            ra, rc, rg, rt;
    logic              len_ok;
    logic              pal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a     <= '1;
            r_c     <= '0;
            r_g     <= '0;
            r_t     <= '0;
            r_len   <= LEN_W'(BASES);
            r_limit <= '0;
            r_mode  <= MODE_FWD;
            r_dedup <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ALLOW_A: r_a     <= i_cfg_data;
                REG_ALLOW_C: r_c     <= i_cfg_data;
                REG_ALLOW_G: r_g     <= i_cfg_data;
                REG_ALLOW_T: r_t     <= i_cfg_data;
                REG_LENGTH:  r_len   <= i_cfg_data[LEN_W-1:0];
                REG_LIMIT:   r_limit <= i_cfg_data[LEN_W-1:0];
                REG_MODE:    r_mode  <= i_cfg_data[MODE_W-1:0];
                REG_DEDUP:   r_dedup <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        active    = ~(t_plane'('1) << r_len);
        allow_any = r_a | r_c | r_g | r_t;
        rshift    = LEN_W'(BASES) - r_len;
        // reverse strand: flip within the active length and complement
        ra = bit_rev(r_t) >> rshift;
        rc = bit_rev(r_g) >> rshift;
        rg = bit_rev(r_c) >> rshift;
        rt = bit_rev(r_a) >> rshift;
        len_ok = (r_len != '0) && (r_len <= LEN_W'(BASES)) && (r_limit <= r_len)
                 && (r_mode <= MODE_BOTH);
        pal = (ra == r_a) && (rc == r_c) && (rg == r_g) && (rt == r_t);

        n_motif.ok     = len_ok && (allow_any == active);
        n_motif.pal    = pal;
        n_motif.fwd_en = (r_mode != MODE_REV);
        n_motif.rev_en = (r_mode != MODE_FWD);
        n_motif.dedup  = (r_mode == MODE_BOTH) && pal && r_dedup;
        n_motif.limit  = r_limit[CNT_W-1:0];
        n_motif.active = active;
        n_motif.fa     = r_a;
        n_motif.fc     = r_c;
        n_motif.fg     = r_g;
        n_motif.ft     = r_t;
        n_motif.ra     = ra;
        n_motif.rc     = rc;
        n_motif.rg     = rg;
        n_motif.rt     = rt;
    end

    always_ff @(posedge i_clk) begin
        r_motif <= n_motif;
    end

    assign o_motif = r_motif;

endmodule

@@ rtl/core/dmm_match.sv @@
// window input register, strand mismatch planes and result register
module dmm_match
    import dmm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  t_plane     i_seq_lo,
    input  t_plane     i_seq_hi,
    input  t_plane     i_valid_mask,
    input  t_motif     i_motif,
    output logic       o_done,
    output logic       o_config_ok,
    output t_plane     o_fwd_mismatch,
    output t_plane     o_rev_mismatch,
    output logic [1:0] o_hit_flags,
    output logic       o_is_palindrome
);

    logic       r_in_vld;
    t_plane     r_lo, r_hi, r_vld;

    logic       r_done;
    logic       r_ok;
    t_plane     r_fwd, r_rev;
    logic [1:0] r_hits;
    logic       r_pal;

    t_plane     n_fwd, n_rev;
    logic [1:0] n_hits;
    t_plane     fwd_raw, rev_raw;
    logic       fwd_hit, rev_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_in_vld <= i_take;
            r_done   <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_lo  <= i_seq_lo;
            r_hi  <= i_seq_hi;
            r_vld <= i_valid_mask;
        end
    end

    always_comb begin
        fwd_raw = mismatch(r_lo, r_hi, r_vld, i_motif.fa, i_motif.fc, i_motif.fg,
                           i_motif.ft, i_motif.active);
        rev_raw = mismatch(r_lo, r_hi, r_vld, i_motif.ra, i_motif.rc, i_motif.rg,
                           i_motif.rt, i_motif.active);
        n_fwd   = (i_motif.ok && i_motif.fwd_en) ? fwd_raw : '0;
        n_rev   = (i_motif.ok && i_motif.rev_en) ? rev_raw : '0;
        fwd_hit = i_motif.ok && i_motif.fwd_en && (popcount(fwd_raw) <= i_motif.limit);
        rev_hit = i_motif.ok && i_motif.rev_en && (popcount(rev_raw) <= i_motif.limit);
        if (i_motif.dedup && (fwd_hit || rev_hit)) begin
            n_hits = 2'b01;
        end else begin
            n_hits = {rev_hit, fwd_hit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_ok   <= i_motif.ok;
            r_fwd  <= n_fwd;
            r_rev  <= n_rev;
            r_hits <= n_hits;
            r_pal  <= i_motif.ok && i_motif.pal;
        end
    end

    assign o_done          = r_done;
    assign o_config_ok     = r_ok;
    assign o_fwd_mismatch  = r_fwd;
    assign o_rev_mismatch  = r_rev;
    assign o_hit_flags     = r_hits;
    assign o_is_palindrome = r_pal;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> o_done)
        else $error("result beat missing after registered window");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |=> !o_done)
        else $error("result beat without a window");

    a_bad_cfg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_config_ok) |-> (o_fwd_mismatch == '0 && o_rev_mismatch == '0
                                       && o_hit_flags == 2'b00 && !o_is_palindrome))
        else $error("nonzero fields with bad configuration");

    a_hit_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit_flags != 2'b00) |-> o_config_ok)
        else $error("strand hit with bad configuration");

endmodule

@@ rtl/core/dna_degenerate_motif_window_match.sv @@
// top level of the degenerate dna motif window matcher
// Takes one 32-base window per clock: a window is accepted whenever start is
// high (busy is always low) and its result beat appears on o_done and the
// result ports once it has passed the window input register and the result
// register, for exactly one cycle; there is no way to hold results off, so
// each beat must be taken while o_done is high. The mismatch planes and the
// popcount compare lie between those two registers.
// Configuration registers feed a derivation register (active mask, reversed
// allow sets, palindrome and validity checks), so a window may start from
// the cycle after a register write; a write applies to windows accepted
// after its write edge and there is no read-back.
module dna_degenerate_motif_window_match
    import dmm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [31:0]      i_seq_lo,
    input  logic [31:0]      i_seq_hi,
    input  logic [31:0]      i_valid_mask,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    output logic             o_done,
    output logic             o_config_ok,
    output logic [31:0]      o_fwd_mismatch,
    output logic [31:0]      o_rev_mismatch,
    output logic [1:0]       o_hit_flags,
    output logic             o_is_palindrome
);

    t_motif motif;

    assign busy = 1'b0;

    dmm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_motif    (motif)
    );

    dmm_match u_match (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (start && !busy),
        .i_seq_lo        (i_seq_lo),
        .i_seq_hi        (i_seq_hi),
        .i_valid_mask    (i_valid_mask),
        .i_motif         (motif),
        .o_done          (o_done),
        .o_config_ok     (o_config_ok),
        .o_fwd_mismatch  (o_fwd_mismatch),
        .o_rev_mismatch  (o_rev_mismatch),
        .o_hit_flags     (o_hit_flags),
        .o_is_palindrome (o_is_palindrome)
    );

endmodule

@@ tb/dna_degenerate_motif_window_match_test.sv @@
// self-checking testbench for the degenerate dna motif window matcher
module dna_degenerate_motif_window_match_test;
    import dmm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;

    typedef struct packed {
        logic        ok;
        logic [31:0] fwd;
        logic [31:0] rev;
        logic [1:0]  hits;
        logic        pal;
    } t_window_result;

    typedef struct {
        logic [31:0]       a;
        logic [31:0]       c;
        logic [31:0]       g;
        logic [31:0]       t;
        logic [5:0]        len;
        logic [5:0]        lim;
        logic [MODE_W-1:0] mode;
        logic              dedup;
    } t_motif_cfg;

    class t_motif_scoreboard;
        logic [31:0]       allow_a;
        logic [31:0]       allow_c;
        logic [31:0]       allow_g;
        logic [31:0]       allow_t;
        logic [5:0]        motif_len;
        logic [5:0]        miss_limit;
        logic [MODE_W-1:0] mode;
        logic              dedup;
        t_window_result    expected_q[$];
        int errors;
        int windows;
        int results;
        int hit_results;
        int bad_cfg_results;
        int pal_results;

        function new();
            allow_a = '1;
            allow_c = '0;
            allow_g = '0;
            allow_t = '0;
            motif_len = 6'd32;
            miss_limit = 6'd0;
            mode = MODE_FWD;
            dedup = 1'b1;
            errors = 0;
            windows = 0;
            results = 0;
            hit_results = 0;
            bad_cfg_results = 0;
            pal_results = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_ALLOW_A: allow_a = data;
                REG_ALLOW_C: allow_c = data;
                REG_ALLOW_G: allow_g = data;
                REG_ALLOW_T: allow_t = data;
                REG_LENGTH:  motif_len = data[5:0];
                REG_LIMIT:   miss_limit = data[5:0];
                REG_MODE:    mode = data[MODE_W-1:0];
                REG_DEDUP:   dedup = data[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] flip_len(logic [31:0] v, int len);
            logic [31:0] r;
            r = '0;
            for (int p = 0; p < len; p++) begin
                r[len-1-p] = v[p];
            end
            return r;
        endfunction

        function logic [31:0] miss_plane(logic [31:0] lo, logic [31:0] hi, logic [31:0] vld,
                                         logic [31:0] a, logic [31:0] c, logic [31:0] g,
                                         logic [31:0] t, logic [31:0] active);
            logic [31:0] m;
            logic        hit;
            m = '0;
            for (int p = 0; p < 32; p++) begin
                case ({hi[p], lo[p]})
                    2'b00:   hit = a[p];
                    2'b01:   hit = c[p];
                    2'b10:   hit = g[p];
                    default: hit = t[p];
                endcase
                m[p] = active[p] & (~hit | ~vld[p]);
            end
            return m;
        endfunction

        function t_window_result predict(logic [31:0] lo, logic [31:0] hi, logic [31:0] vld);
            t_window_result r;
            logic [31:0]    active;
            logic [31:0]    ra;
            logic [31:0]    rc;
            logic [31:0]    rg;
            logic [31:0]    rt;
            int             len;
            r = '0;
            len = motif_len;
            if (len < 1 || len > int'(BASES) || miss_limit > motif_len || mode > MODE_BOTH) begin
                return r;
            end
            active = (len == 32) ? 32'hffff_ffff : (32'd1 << len) - 32'd1;
            if ((allow_a | allow_c | allow_g | allow_t) != active) begin
                return r;
            end
            ra = flip_len(allow_t, len);
            rc = flip_len(allow_g, len);
            rg = flip_len(allow_c, len);
            rt = flip_len(allow_a, len);
            r.ok = 1'b1;
            r.pal = (ra == allow_a) && (rc == allow_c) && (rg == allow_g) && (rt == allow_t);
            if (mode != MODE_REV) begin
                r.fwd = miss_plane(lo, hi, vld, allow_a, allow_c, allow_g, allow_t, active);
                if ($countones(r.fwd) <= miss_limit) r.hits[0] = 1'b1;
            end
            if (mode != MODE_FWD) begin
                r.rev = miss_plane(lo, hi, vld, ra, rc, rg, rt, active);
                if ($countones(r.rev) <= miss_limit) r.hits[1] = 1'b1;
            end
            // palindromic motif seen on both strands counts once, as forward
            if (mode == MODE_BOTH && r.pal && dedup && r.hits != 2'b00) r.hits = 2'b01;
            return r;
        endfunction

        function void note_window(logic [31:0] lo, logic [31:0] hi, logic [31:0] vld);
            expected_q.push_back(predict(lo, hi, vld));
            windows++;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            if (errors < 100) begin
                $display("mismatch: %s got %h want %h (result %0d)", what, got, want, results);
            end
            errors++;
        endtask

        task check_result(t_window_result got);
            t_window_result want;
            if (expected_q.size() == 0) begin
                report("result beat with no window pending", 32'd0, 32'd0);
                return;
            end
            want = expected_q.pop_front();
            results++;
            if (got.ok != want.ok) report("config_ok", 32'(got.ok), 32'(want.ok));
            if (got.fwd != want.fwd) report("fwd_mismatch", got.fwd, want.fwd);
            if (got.rev != want.rev) report("rev_mismatch", got.rev, want.rev);
            if (got.hits != want.hits) report("hit_flags", 32'(got.hits), 32'(want.hits));
            if (got.pal != want.pal) report("is_palindrome", 32'(got.pal), 32'(want.pal));
            if (!want.ok) bad_cfg_results++;
            if (want.hits != 2'b00) hit_results++;
            if (want.pal) pal_results++;
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [31:0]       i_seq_lo = '0;
    logic [31:0]       i_seq_hi = '0;
    logic [31:0]       i_valid_mask = '0;
    logic              i_cfg_we = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx = '0;
    logic [31:0]       i_cfg_data = '0;
    logic              o_done;
    logic              o_config_ok;
    logic [31:0]       o_fwd_mismatch;
    logic [31:0]       o_rev_mismatch;
    logic [1:0]        o_hit_flags;
    logic              o_is_palindrome;

    t_motif_scoreboard sb;
    int idle_pct = 0;
    int n_settings = 0;

    dna_degenerate_motif_window_match u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_seq_lo        (i_seq_lo),
        .i_seq_hi        (i_seq_hi),
        .i_valid_mask    (i_valid_mask),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_config_ok     (o_config_ok),
        .o_fwd_mismatch  (o_fwd_mismatch),
        .o_rev_mismatch  (o_rev_mismatch),
        .o_hit_flags     (o_hit_flags),
        .o_is_palindrome (o_is_palindrome)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL dna_degenerate_motif_window_match");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                sb.check_result({o_config_ok, o_fwd_mismatch, o_rev_mismatch,
                                 o_hit_flags, o_is_palindrome});
            end
            if (i_cfg_we) sb.set_reg(i_cfg_idx, i_cfg_data);
            if (start && !busy) sb.note_window(i_seq_lo, i_seq_hi, i_valid_mask);
        end
    end

    function automatic logic [3:0] rand_set();
        logic [3:0] one;
        one = 4'b0001;
        if ($urandom_range(1)) return one << $urandom_range(3);
        return 4'($urandom_range(15, 1));
    endfunction

    // base sets are indexed A, C, G, T; the complement swaps A with T and C with G
    function automatic logic [3:0] comp_set(logic [3:0] s);
        return {s[0], s[1], s[2], s[3]};
    endfunction

    function automatic t_motif_cfg make_motif(int len, bit palin, int lim,
                                              logic [MODE_W-1:0] mode, logic dedup);
        t_motif_cfg m;
        logic [3:0] sets [32];
        int         q;
        m.a = '0;
        m.c = '0;
        m.g = '0;
        m.t = '0;
        m.len = 6'(len);
        m.lim = 6'(lim);
        m.mode = mode;
        m.dedup = dedup;
        for (int p = 0; p < len; p++) begin
            q = len - 1 - p;
            if (!palin || p < q) begin
                sets[p] = rand_set();
            end else if (p == q) begin
                case ($urandom_range(2))
                    0:       sets[p] = 4'b1001;
                    1:       sets[p] = 4'b0110;
                    default: sets[p] = 4'b1111;
                endcase
            end else begin
                sets[p] = comp_set(sets[q]);
            end
            m.a[p] = sets[p][0];
            m.c[p] = sets[p][1];
            m.g[p] = sets[p][2];
            m.t[p] = sets[p][3];
        end
        return m;
    endfunction

    function automatic t_motif_cfg rand_cfg();
        t_motif_cfg m;
        int len;
        int lim;
        int p;
        int r;
        r = $urandom_range(99);
        if (r < 20) len = 32;
        else if (r < 30) len = 1;
        else if (r < 40) len = 2;
        else len = $urandom_range(32, 1);
        r = $urandom_range(99);
        if (r < 25) lim = 0;
        else if (r < 35) lim = len;
        else lim = $urandom_range(len < 5 ? len : 5);
        m = make_motif(len, $urandom_range(99) < 40, lim, MODE_W'($urandom_range(2)),
                       1'($urandom_range(1)));
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(5))
                0: m.len = 6'd0;
                1: m.len = 6'($urandom_range(63, 33));
                2: m.lim = 6'(len + $urandom_range(4, 1));
                3: m.mode = MODE_BAD;
                4: begin
                    if (len < 32) begin
                        p = $urandom_range(31, len);
                        m.c[p] = 1'b1;
                    end else begin
                        p = $urandom_range(31);
                        m.a[p] = 1'b0;
                        m.c[p] = 1'b0;
                        m.g[p] = 1'b0;
                        m.t[p] = 1'b0;
                    end
                end
                default: begin
                    p = $urandom_range(len - 1);
                    m.a[p] = 1'b0;
                    m.c[p] = 1'b0;
                    m.g[p] = 1'b0;
                    m.t[p] = 1'b0;
                end
            endcase
        end
        return m;
    endfunction

    function automatic logic [3:0] set_at(t_motif_cfg m, bit rev, int p, int len);
        int q;
        if (!rev) return {m.t[p], m.g[p], m.c[p], m.a[p]};
        q = len - 1 - p;
        return comp_set({m.t[q], m.g[q], m.c[q], m.a[q]});
    endfunction

    // window that matches the motif on one strand, then up to n_err positions spoiled
    task automatic make_window(t_motif_cfg m, bit rev, int n_err,
                               output logic [31:0] lo, output logic [31:0] hi,
                               output logic [31:0] vld);
        int         len;
        int         p;
        logic [3:0] s;
        logic [1:0] b;
        lo = $urandom;
        hi = $urandom;
        vld = $urandom_range(1) ? 32'hffff_ffff : $urandom;
        len = (m.len > 6'd32) ? 32 : int'(m.len);
        for (int i = 0; i < len; i++) begin
            s = set_at(m, rev, i, len);
            vld[i] = 1'b1;
            if (s != 4'b0000) begin
                b = 2'($urandom_range(3));
                while (!s[b]) b = b + 2'd1;
                lo[i] = b[0];
                hi[i] = b[1];
            end
        end
        if (len > 0) begin
            repeat (n_err) begin
                p = $urandom_range(len - 1);
                s = set_at(m, rev, p, len);
                if (s == 4'b1111 || $urandom_range(3) == 0) begin
                    vld[p] = 1'b0;
                end else begin
                    b = 2'($urandom_range(3));
                    while (s[b]) b = b + 2'd1;
                    lo[p] = b[0];
                    hi[p] = b[1];
                end
            end
        end
    endtask

    task automatic send_window(logic [31:0] lo, logic [31:0] hi, logic [31:0] vld);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_seq_lo <= lo;
        i_seq_hi <= hi;
        i_valid_mask <= vld;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] with_junk(logic [31:0] v, int w, bit junk);
        logic [31:0] mask;
        mask = (32'd1 << w) - 32'd1;
        return junk ? (($urandom & ~mask) | v) : v;
    endfunction

    task automatic configure(t_motif_cfg m, bit junk);
        drain();
        write_reg(REG_ALLOW_A, m.a);
        write_reg(REG_ALLOW_C, m.c);
        write_reg(REG_ALLOW_G, m.g);
        write_reg(REG_ALLOW_T, m.t);
        write_reg(REG_LENGTH, with_junk(32'(m.len), 6, junk));
        write_reg(REG_LIMIT, with_junk(32'(m.lim), 6, junk));
        write_reg(REG_MODE, with_junk(32'(m.mode), MODE_W, junk));
        write_reg(REG_DEDUP, with_junk(32'(m.dedup), 1, junk));
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic run_phase(int n, int pct);
        t_motif_cfg  m;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] vld;
        int          n_err;
        bit          rev;
        m = rand_cfg();
        configure(m, $urandom_range(3) == 0);
        idle_pct = pct;
        repeat (n) begin
            if ($urandom_range(99) < 70) begin
                rev = (m.mode == MODE_REV) || (m.mode == MODE_BOTH && $urandom_range(1) == 1);
                case ($urandom_range(3))
                    0:       n_err = 0;
                    1:       n_err = m.lim;
                    2:       n_err = m.lim + 1;
                    default: n_err = $urandom_range(4);
                endcase
                make_window(m, rev, n_err, lo, hi, vld);
            end else begin
                lo = $urandom;
                hi = $urandom;
                vld = $urandom_range(1) ? 32'hffff_ffff : $urandom;
            end
            send_window(lo, hi, vld);
        end
    endtask

    initial begin
        t_motif_cfg  m;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] vld;
        int          idle_plan [4];
        sb = new();
        idle_plan = '{0, 53, 0, 34};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // power-on setting: all-A motif over the full window
        send_window(32'h0, 32'h0, 32'hffff_ffff);
        send_window(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_window(32'h0, 32'h0, 32'h0);
        send_window(32'hffff_ffff, 32'h0, 32'hffff_ffff);
        send_window($urandom, $urandom, $urandom);

        // palindromic motif, both strands, with and without dedup
        m = make_motif(32, 1'b1, 2, MODE_BOTH, 1'b1);
        configure(m, 1'b0);
        make_window(m, 1'b0, 0, lo, hi, vld);
        send_window(lo, hi, vld);
        make_window(m, 1'b1, 0, lo, hi, vld);
        send_window(lo, hi, vld);
        make_window(m, 1'b0, 3, lo, hi, vld);
        send_window(lo, hi, vld);
        m.dedup = 1'b0;
        configure(m, 1'b0);
        make_window(m, 1'b0, 0, lo, hi, vld);
        send_window(lo, hi, vld);
        make_window(m, 1'b1, 1, lo, hi, vld);
        send_window(lo, hi, vld);

        // single position, reverse strand, every base
        m = make_motif(1, 1'b0, 0, MODE_REV, 1'b1);
        configure(m, 1'b0);
        for (int b = 0; b < 4; b++) begin
            lo = $urandom;
            hi = $urandom;
            lo[0] = b[0];
            hi[0] = b[1];
            send_window(lo, hi, $urandom | 32'd1);
        end

        // budget equal to the full length
        m = make_motif(32, 1'b0, 32, MODE_BOTH, 1'b0);
        configure(m, 1'b0);
        send_window($urandom, $urandom, $urandom);
        send_window($urandom, $urandom, 32'h0);

        // invalid settings
        m = make_motif(8, 1'b0, 1, MODE_FWD, 1'b1);
        m.len = 6'd0;
        configure(m, 1'b0);
        send_window($urandom, $urandom, $urandom);
        m.len = 6'd8;
        m.mode = MODE_BAD;
        configure(m, 1'b0);
        send_window($urandom, $urandom, $urandom);
        m.mode = MODE_FWD;
        m.lim = 6'd9;
        configure(m, 1'b0);
        send_window($urandom, $urandom, $urandom);
        m.lim = 6'd1;
        m.g[20] = 1'b1;
        configure(m, 1'b0);
        send_window($urandom, $urandom, $urandom);

        for (int i = 0; i < 20; i++) begin
            run_phase(70, idle_plan[i % 4]);
        end

        drain();
        repeat (5) @(posedge i_clk);
        if (sb.expected_q.size() != 0) begin
            sb.report("windows left without a result", 32'(sb.expected_q.size()), 32'd0);
        end
        $display("ran %0d windows over %0d motif settings, %0d results checked",
                 sb.windows, n_settings, sb.results);
        $display("%0d results with a strand hit, %0d palindromic, %0d under invalid settings",
                 sb.hit_results, sb.pal_results, sb.bad_cfg_results);
        if (sb.errors == 0) begin
            $display("PASS dna_degenerate_motif_window_match");
        end else begin
            $display("FAIL dna_degenerate_motif_window_match");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/dmm_pkg.sv
rtl/core/dmm_cfg.sv
rtl/core/dmm_match.sv
rtl/core/dna_degenerate_motif_window_match.sv
tb/dna_degenerate_motif_window_match_test.sv
